@@ hdl/tcbdr_pkg.sv @@
package tcbdr_pkg;

    // Default array size
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    // Field widths
    localparam int OP_W       = 3;
    localparam int COORD_W    = 11;
    localparam int COLOUR_W   = 8;
    localparam int CELL_W     = 3 * COLOUR_W;
    localparam int COLS_W     = 8;
    localparam int ROWS_W     = 7;
    localparam int RECT_W     = 12;
    localparam int PROD_W     = COLS_W + ROWS_W;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 72;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 1'd1;
    localparam logic [COLS_W-1:0] RST_ACTIVE_COLS = 8'd80;
    localparam logic [ROWS_W-1:0] RST_ACTIVE_ROWS = 7'd25;

    // Glyph written into lines freed by a scroll
    localparam logic [COLOUR_W-1:0] SPACE_GLYPH = 8'h20;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 3'd0,
        OP_GET    = 3'd1,
        OP_SCROLL = 3'd2,
        OP_CLEAN  = 3'd3,
        OP_MARK   = 3'd4,
        OP_POP    = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [6:0]                pad;
        logic [7:0]                scroll_lines;
        logic [COLOUR_W-1:0]       back_colour;
        logic [COLOUR_W-1:0]       fore_colour;
        logic [COLOUR_W-1:0]       glyph;
        logic signed [COORD_W-1:0] row;
        logic signed [COORD_W-1:0] col;
        logic [OP_W-1:0]           opcode;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                pad;
        logic [RECT_W-1:0]         rect_height;
        logic [RECT_W-1:0]         rect_width;
        logic signed [COORD_W-1:0] rect_top;
        logic signed [COORD_W-1:0] rect_left;
        logic [COLOUR_W-1:0]       cell_back;
        logic [COLOUR_W-1:0]       cell_fore;
        logic [COLOUR_W-1:0]       cell_glyph;
    } t_out_item;

    // Which product the shared multiplier forms
    typedef enum logic [1:0] {
        MUL_NONE  = 2'd0,
        MUL_ADDR  = 2'd1,
        MUL_TOTAL = 2'd2,
        MUL_SHIFT = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        t_mul_sel mul;
        logic     sweep_init;
        logic     sweep_copy;
        logic     sweep_run;
        logic     cell_write;
        logic     cell_read;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    sweep_done;
        logic    out_free;
        logic    rect_w_zero;
        logic    rect_h_zero;
    } t_dp_sts;

endpackage

@@ hdl/tcbdr_ram.sv @@
module tcbdr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tcbdr_dp.sv @@
module tcbdr_dp import tcbdr_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output t_out_item             o_out_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] lo;
        logic [RECT_W-1:0]         len;
    } t_span;

    function automatic logic [COLS_W-1:0] clamp_coord(
        input logic signed [COORD_W-1:0] v,
        input logic [COLS_W-1:0]         n
    );
        logic signed [COORD_W:0] vx;
        logic signed [COORD_W:0] nx;
        vx = {v[COORD_W-1], v};
        nx = $signed({{(COORD_W + 1 - COLS_W){1'b0}}, n});
        if (vx >= nx) begin
            return n - 1'b1;
        end else if (v[COORD_W-1]) begin
            return '0;
        end else begin
            return v[COLS_W-1:0];
        end
    endfunction

    // Stretch one axis of the rectangle to cover v
    function automatic t_span grow(input t_span s, input logic signed [COORD_W-1:0] v);
        logic signed [13:0] lo;
        logic signed [13:0] ln;
        logic signed [13:0] vv;
        t_span r;
        lo = 14'(s.lo);
        ln = $signed({2'b00, s.len});
        vv = 14'(v);
        r  = s;
        if (vv < lo) begin
            r.len = RECT_W'(ln + lo - vv);
            r.lo  = v;
        end else if (vv + 14'sd1 > lo + ln) begin
            r.len = RECT_W'(vv + 14'sd1 - lo);
        end
        return r;
    endfunction

    // Configuration
    logic [COLS_W-1:0] r_cols;
    logic [ROWS_W-1:0] r_rows;
    logic [COLS_W-1:0] eff_cols;
    logic [ROWS_W-1:0] eff_rows;

    // Captured item
    t_opcode                   r_op;
    logic [COLS_W-1:0]         r_x;
    logic [ROWS_W-1:0]         r_y;
    logic signed [COORD_W-1:0] r_col;
    logic signed [COORD_W-1:0] r_row;
    logic [CELL_W-1:0]         r_cell;
    logic [7:0]                r_lines;
    logic [COLS_W-1:0]         in_x;
    logic [COLS_W-1:0]         in_y_wide;

    // Multiplier and products
    logic [ROWS_W-1:0] n_lines;
    logic [ROWS_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0] r_prod;
    logic [CW-1:0]     r_total;
    logic [CW-1:0]     r_shift;
    logic [AW-1:0]     cell_addr;

    // Sweep engine
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_widx;
    logic          r_wv;
    logic          r_wcopy;
    logic          r_copy;
    logic [CW:0]   sw_src;
    logic          sw_issue;
    logic          sw_rd;

    // Cell memory ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic [CELL_W-1:0] fill_cell;

    // Dirty rectangle
    t_span                     r_xs;
    t_span                     r_ys;
    logic signed [COORD_W-1:0] mk_x;
    logic signed [COORD_W-1:0] mk_y;
    t_span                     grow_x;
    t_span                     grow_y;

    // Result
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= RST_ACTIVE_COLS;
            r_rows <= RST_ACTIVE_ROWS;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_ACTIVE_COLS) begin
                r_cols <= i_cfg_data;
            end else begin
                r_rows <= i_cfg_data[ROWS_W-1:0];
            end
        end
    end

    // Zero counts as one, saturate at the array size
    assign eff_cols = (r_cols == '0) ? COLS_W'(1) :
                      ((32'(r_cols) > MAX_COLS) ? COLS_W'(MAX_COLS) : r_cols);
    assign eff_rows = (r_rows == '0) ? ROWS_W'(1) :
                      ((32'(r_rows) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : r_rows);

    assign in_x      = clamp_coord(i_item.col, eff_cols);
    assign in_y_wide = clamp_coord(i_item.row, {1'b0, eff_rows});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_opcode'(i_item.opcode);
            r_x     <= in_x;
            r_y     <= in_y_wide[ROWS_W-1:0];
            r_col   <= i_item.col;
            r_row   <= i_item.row;
            r_cell  <= {i_item.back_colour, i_item.fore_colour, i_item.glyph};
            r_lines <= i_item.scroll_lines;
        end
    end

    // Shared multiplier: row * cols, rows * cols, lines * cols
    assign n_lines = (r_lines > {1'b0, eff_rows}) ? eff_rows : r_lines[ROWS_W-1:0];

    always_comb begin
        unique case (i_cmd.mul)
            MUL_ADDR:  mul_a = r_y;
            MUL_TOTAL: mul_a = eff_rows;
            MUL_SHIFT: mul_a = n_lines;
            MUL_NONE:  mul_a = '0;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(eff_cols);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul == MUL_ADDR) begin
            r_prod <= mul_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= CW'(DEPTH);
            r_shift <= '0;
        end else begin
            if (i_cmd.mul == MUL_TOTAL) begin
                r_total <= CW'(mul_p);
            end
            if (i_cmd.mul == MUL_SHIFT) begin
                r_shift <= CW'(mul_p);
            end else if (i_cmd.sweep_init) begin
                r_shift <= '0;
            end
        end
    end

    assign cell_addr = AW'({1'b0, r_prod} + (PROD_W + 1)'(r_x));

    // Sweep: issue reads ahead, write each cell in the following cycle
    assign sw_src   = {1'b0, r_idx} + {1'b0, r_shift};
    assign sw_issue = (r_idx < r_total);
    assign sw_rd    = sw_issue && r_copy && (sw_src < {1'b0, r_total});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_widx  <= '0;
            r_wv    <= 1'b0;
            r_wcopy <= 1'b0;
            r_copy  <= 1'b0;
        end else if (i_cmd.sweep_init) begin
            r_idx  <= '0;
            r_wv   <= 1'b0;
            r_copy <= i_cmd.sweep_copy;
        end else if (i_cmd.sweep_run) begin
            r_idx   <= r_idx + CW'(sw_issue);
            r_wv    <= sw_issue;
            r_widx  <= r_idx;
            r_wcopy <= sw_rd;
        end
    end

    assign fill_cell = r_copy ? {{(CELL_W - COLOUR_W){1'b0}}, SPACE_GLYPH} : '0;

    assign ram_we    = (i_cmd.sweep_run && r_wv) || i_cmd.cell_write;
    assign ram_waddr = i_cmd.cell_write ? cell_addr : AW'(r_widx);
    assign ram_wdata = i_cmd.cell_write ? r_cell : (r_wcopy ? ram_rdata : fill_cell);
    assign ram_re    = (i_cmd.sweep_run && sw_rd) || i_cmd.cell_read;
    assign ram_raddr = i_cmd.cell_read ? cell_addr : AW'(sw_src);

    tcbdr_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Put marks the clamped cell, mark-dirty the raw coordinates
    assign mk_x   = (r_op == OP_PUT) ? $signed({3'b000, r_x}) : r_col;
    assign mk_y   = (r_op == OP_PUT) ? $signed({4'b0000, r_y}) : r_row;
    assign grow_x = grow(r_xs, mk_x);
    assign grow_y = grow(r_ys, mk_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xs <= '0;
            r_ys <= '0;
        end else if (i_cmd.finish) begin
            unique case (r_op)
                OP_PUT, OP_MARK: begin
                    if (r_xs.len == '0) begin
                        r_xs <= '{lo: mk_x, len: RECT_W'(1)};
                        r_ys <= '{lo: mk_y, len: RECT_W'(1)};
                    end else begin
                        r_xs <= grow_x;
                        r_ys <= grow_y;
                    end
                end
                OP_SCROLL, OP_CLEAN: begin
                    r_xs <= '{lo: '0, len: RECT_W'(eff_cols)};
                    r_ys <= '{lo: '0, len: RECT_W'(eff_rows)};
                end
                OP_POP: begin
                    r_xs <= '0;
                    r_ys <= '0;
                end
                default: begin
                    r_xs <= r_xs;
                end
            endcase
        end
    end

    always_comb begin
        n_out = '0;
        if (r_op == OP_GET) begin
            n_out.cell_glyph = ram_rdata[COLOUR_W-1:0];
            n_out.cell_fore  = ram_rdata[2*COLOUR_W-1:COLOUR_W];
            n_out.cell_back  = ram_rdata[CELL_W-1:2*COLOUR_W];
        end
        if (r_op == OP_POP) begin
            n_out.rect_left   = r_xs.lo;
            n_out.rect_top    = r_ys.lo;
            n_out.rect_width  = r_xs.len;
            n_out.rect_height = r_ys.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_item  = r_out;
    assign o_out_valid = r_out_valid;

    assign o_sts.op          = r_op;
    assign o_sts.sweep_done  = r_wv && (r_widx == r_total - CW'(1));
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.rect_w_zero = (r_xs.len == '0);
    assign o_sts.rect_h_zero = (r_ys.len == '0);

endmodule

@@ hdl/tcbdr_ctrl.sv @@
module tcbdr_ctrl import tcbdr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_ADDR   = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_ACCESS = 7'b0010000,
        S_SWEEP  = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_run = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ADDR;
                end
            end
            S_ADDR: begin
                unique case (i_sts.op)
                    OP_PUT, OP_GET: begin
                        o_cmd.mul = MUL_ADDR;
                        n_state   = S_ACCESS;
                    end
                    OP_SCROLL: begin
                        o_cmd.mul = MUL_TOTAL;
                        n_state   = S_SHIFT;
                    end
                    OP_CLEAN: begin
                        o_cmd.mul        = MUL_TOTAL;
                        o_cmd.sweep_init = 1'b1;
                        n_state          = S_SWEEP;
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_SHIFT: begin
                o_cmd.mul        = MUL_SHIFT;
                o_cmd.sweep_init = 1'b1;
                o_cmd.sweep_copy = 1'b1;
                n_state          = S_SWEEP;
            end
            S_ACCESS: begin
                o_cmd.cell_write = (i_sts.op == OP_PUT);
                o_cmd.cell_read  = (i_sts.op == OP_GET);
                n_state          = S_RESULT;
            end
            S_SWEEP: begin
                o_cmd.sweep_run = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // Hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/text_cell_buffer_dirty_rect_core.sv @@
// Channel   Dir  Width  Transfer when        Contents
// s_axis    in   64     tvalid && tready     one command item
// m_axis    out  72     tvalid && tready     one result item per command
// i_cfg_*   in   1+8    i_cfg_we high        active_cols (0), active_rows (1)
//
// After reset a clearing pass writes every cell to zero, one cell per cycle; no input is taken
// until it ends. Put and get step through address, access and result; mark-dirty, pop and
// unused codes through address and result; clean and scroll walk the active cells through the
// single write port of the cell RAM, one cell a cycle. A command taken while a result waits
// in the output register holds in its last step until that result is taken.
module text_cell_buffer_dirty_rect_core import tcbdr_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Command stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // opcode[2:0], col[13:3], row[24:14], glyph[32:25], fore_colour[40:33],
    // back_colour[48:41], scroll_lines[56:49], zero[63:57]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // cell_glyph[7:0], cell_fore[15:8], cell_back[23:16], rect_left[34:24],
    // rect_top[45:35], rect_width[57:46], rect_height[69:58], zero[71:70]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    t_out_item out_item;

    // Sequencer: steps each command through the address, shift, access, sweep and result phases its opcode needs
    tcbdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: config, clamp, multiplier, sweep engine, cell RAM, rectangle
    tcbdr_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (t_in_item'(s_axis_tdata)),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_item  (out_item),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = out_item;

    // One command in flight: a transfer in closes the input side next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a command is in flight");

    // Cell RAM writes never overlap the input being open
    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.cell_write || cmd.sweep_run) |-> !s_axis_tready)
        else $error("cell write while accepting input");

    // The dirty rectangle is empty in both axes or in neither
    a_rect_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.rect_w_zero == sts.rect_h_zero)
        else $error("dirty rectangle width and height disagree on empty");

endmodule
